>>> hdl/rrqi_pkg.sv
package rrqi_pkg;

	// action codes; the unused code is decoded as a pull
	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_PULL   = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_DELIVERED = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_ACCEPTED  = 3'd2,
		ST_FULL      = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	localparam int WORD_W  = 32;
	localparam int INDEX_W = 3;

	// input transaction
	typedef struct packed {
		logic [1:0]               action;
		logic [INDEX_W-1:0]       list_index;
		logic signed [WORD_W-1:0] value;
	} item_t;

	// result transaction
	typedef struct packed {
		logic signed [WORD_W-1:0] value_out;
		logic [2:0]               status;
		logic                     more_left;
	} result_t;

endpackage

>>> hdl/round_robin_queue_interleaver.sv
// Round-robin queue interleaver: NUM_QUEUES queues of signed 32-bit words,
// QUEUE_DEPTH words each, held in one synchronous memory. Append stores a word
// at a queue's tail, pull returns the front word of the first non-empty queue
// at or after the turn pointer and moves the pointer past it, clear empties all
// queues at once. One transaction is taken every clock cycle (busy stays low);
// its result appears with done in the cycle after acceptance, the cycle the
// memory read data comes back. Results cannot be stalled: sample result
// whenever done is high. The queue contents are not reset; head and fill
// counts are, so no clearing pass is needed after reset.
module round_robin_queue_interleaver #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rrqi_pkg::item_t  item,
	output logic             done,
	output rrqi_pkg::result_t result
);
	import rrqi_pkg::*;

	localparam int QW = $clog2(NUM_QUEUES);
	localparam int DW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [DW:0] DEPTH_C  = (DW+1)'(QUEUE_DEPTH);
	localparam logic [FW-1:0] FULL_C = FW'(QUEUE_DEPTH);
	localparam logic [QW:0] LAST_Q   = (QW+1)'(NUM_QUEUES - 1);

	// control state
	logic [DW-1:0]   head_q [NUM_QUEUES];
	logic [FW-1:0]   fill_q [NUM_QUEUES];
	logic [QW-1:0]   ptr_q;

	// word storage
	logic [WORD_W-1:0] store_q [NUM_QUEUES][QUEUE_DEPTH];

	// result stage
	logic              valid_s1;
	logic              deliver_s1;
	logic [2:0]        status_s1;
	logic              more_s1;
	logic [WORD_W-1:0] rd_data_s1;

	logic                  accept;
	logic                  is_append;
	logic                  is_clear;
	logic                  is_pull;
	logic [31:0]           idx_wide;
	logic                  idx_ok;
	logic [QW-1:0]         app_q;
	logic [NUM_QUEUES-1:0] nonempty;
	logic [NUM_QUEUES-1:0] upper;
	logic [NUM_QUEUES-1:0] cand;
	logic [NUM_QUEUES-1:0] pick_oh;
	logic [QW-1:0]         pick_q;
	logic                  any_left;
	logic [QW-1:0]         sel_q;
	logic [DW-1:0]         sel_head;
	logic [FW-1:0]         sel_fill;
	logic [DW:0]           tail_sum;
	logic [DW-1:0]         tail_pos;
	logic [DW:0]           head_inc;
	logic [DW-1:0]         head_next;
	logic                  app_ok;
	logic                  pull_ok;
	logic [QW:0]           ptr_inc;
	logic [QW-1:0]         ptr_next;
	logic [NUM_QUEUES-1:0] nonempty_next;
	logic [2:0]            status_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// decode
	assign is_append = (item.action == ACT_APPEND);
	assign is_clear  = (item.action == ACT_CLEAR);
	assign is_pull   = !is_append && !is_clear;
	assign idx_wide  = 32'(item.list_index);
	assign idx_ok    = (idx_wide < 32'(NUM_QUEUES));
	assign app_q     = idx_wide[QW-1:0];

	// occupancy flags
	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			nonempty[i] = (fill_q[i] != '0);
		end
	end
	assign any_left = |nonempty;

	// rotating priority pick starting at the turn pointer
	always_comb begin
		upper   = nonempty & ({NUM_QUEUES{1'b1}} << ptr_q);
		cand    = (|upper) ? upper : nonempty;
		pick_oh = cand & (~cand + NUM_QUEUES'(1));
		pick_q  = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (pick_oh[i]) begin
				pick_q = pick_q | QW'(i);
			end
		end
	end

	// one queue's counters are looked at per transaction
	assign sel_q    = is_append ? app_q : pick_q;
	assign sel_head = head_q[sel_q];
	assign sel_fill = fill_q[sel_q];

	// tail position for append, wrapped
	always_comb begin
		tail_sum = (DW+1)'(sel_head) + (DW+1)'(sel_fill);
		if (tail_sum >= DEPTH_C) begin
			tail_sum = tail_sum - DEPTH_C;
		end
		tail_pos = tail_sum[DW-1:0];
	end

	// head advance for pull, wrapped
	always_comb begin
		head_inc  = (DW+1)'(sel_head) + (DW+1)'(1);
		head_next = (head_inc >= DEPTH_C) ? '0 : head_inc[DW-1:0];
	end

	assign app_ok  = is_append && idx_ok && (sel_fill != FULL_C);
	assign pull_ok = is_pull && any_left;

	// pointer moves one past the served queue
	always_comb begin
		ptr_inc  = (QW+1)'(pick_q) + (QW+1)'(1);
		ptr_next = ((QW+1)'(pick_q) == LAST_Q) ? '0 : ptr_inc[QW-1:0];
	end

	// occupancy after this transaction and its status
	always_comb begin
		nonempty_next = nonempty;
		status_d      = ST_FULL;
		priority if (is_clear) begin
			nonempty_next = '0;
			status_d      = ST_CLEARED;
		end else if (is_append) begin
			if (app_ok) begin
				nonempty_next[sel_q] = 1'b1;
				status_d             = ST_ACCEPTED;
			end else begin
				status_d = ST_FULL;
			end
		end else begin
			if (pull_ok) begin
				if (sel_fill == FW'(1)) begin
					nonempty_next[sel_q] = 1'b0;
				end
				status_d = ST_DELIVERED;
			end else begin
				status_d = ST_EMPTY;
			end
		end
	end

	// head, fill and pointer update at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			ptr_q <= '0;
		end else if (accept) begin
			if (is_clear) begin
				for (int i = 0; i < NUM_QUEUES; i++) begin
					head_q[i] <= '0;
					fill_q[i] <= '0;
				end
				ptr_q <= '0;
			end else if (app_ok) begin
				fill_q[sel_q] <= sel_fill + FW'(1);
			end else if (pull_ok) begin
				head_q[sel_q] <= head_next;
				fill_q[sel_q] <= sel_fill - FW'(1);
				ptr_q         <= ptr_next;
			end
		end
	end

	// word memory: write on append, registered read on pull
	always_ff @(posedge clk) begin
		if (accept && app_ok) begin
			store_q[sel_q][tail_pos] <= item.value;
		end
		if (accept && pull_ok) begin
			rd_data_s1 <= store_q[sel_q][sel_head];
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			deliver_s1 <= 1'b0;
		end else begin
			valid_s1   <= accept;
			deliver_s1 <= accept && pull_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			more_s1   <= |nonempty_next;
		end
	end

	// result transaction
	assign done             = valid_s1;
	assign result.value_out = deliver_s1 ? rd_data_s1 : '0;
	assign result.status    = status_s1;
	assign result.more_left = more_s1;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rrqi_pkg::*;

	localparam int NQ    = 8;
	localparam int DEPTH = 256;
	localparam int ITEMS = 1250;
	// the one action code the package leaves unnamed; the block treats it as a pull
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// one pending transaction; settle makes the sender wait for all results first
	typedef struct {
		item_t op;
		bit    settle;
	} queued_op_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	queued_op_t         op_backlog[$];
	result_t            due_results[$];
	logic signed [31:0] mirror_words[NQ][$];
	logic [2:0]         mirror_turn = '0;
	int                 accepted_count = 0;
	int                 results_seen = 0;
	int                 fault_count = 0;
	int                 gap_left = 0;
	int                 idle_pct = 10;
	int                 status_tally[5];

	round_robin_queue_interleaver #(
		.NUM_QUEUES(NQ),
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// reset at start, released once
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// expected result of one transaction, updating the mirrored queues
	function automatic result_t interleave_step(item_t op);
		result_t r;
		int      q;
		int      k;
		r = '0;
		case (op.action)
			ACT_APPEND: begin
				if (op.list_index >= NQ || mirror_words[op.list_index].size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					mirror_words[op.list_index].insert(mirror_words[op.list_index].size(),
						op.value);
					r.status = ST_ACCEPTED;
				end
			end
			ACT_CLEAR: begin
				foreach (mirror_words[i]) mirror_words[i].delete();
				mirror_turn = '0;
				r.status = ST_CLEARED;
			end
			default: begin
				// pull: first non-empty queue at or after the turn pointer
				r.status = ST_EMPTY;
				for (k = 0; k < NQ; k++) begin
					q = (mirror_turn + k) % NQ;
					if (mirror_words[q].size() != 0) begin
						r.value_out = mirror_words[q].pop_front();
						mirror_turn = 3'((q + 1) % NQ);
						r.status = ST_DELIVERED;
						break;
					end
				end
			end
		endcase
		r.more_left = 1'b0;
		foreach (mirror_words[i]) if (mirror_words[i].size() != 0) r.more_left = 1'b1;
		return r;
	endfunction

	task automatic add_op(logic [1:0] act, logic [2:0] idx, logic [31:0] val,
			bit settle = 1'b0);
		queued_op_t e;
		e.op.action     = act;
		e.op.list_index = idx;
		e.op.value      = val;
		e.settle        = settle;
		op_backlog.insert(op_backlog.size(), e);
	endtask

	// mostly random words, with the extremes mixed in
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// load a subset of queues, then pull them back out, with some noise
	task automatic mixed_phase();
		logic [7:0] mask;
		logic [2:0] idx;
		int         loads;
		int         pulls;
		int         sel;
		int         n;
		mask  = 8'($urandom_range(1, 255));
		loads = $urandom_range(4, 28);
		pulls = loads + $urandom_range(0, 4);
		for (n = 0; n < loads; n++) begin
			do idx = 3'($urandom_range(0, NQ - 1)); while (!mask[idx]);
			if ($urandom_range(0, 19) == 0)
				add_op(ACT_PULL, 3'($urandom()), $urandom());
			else
				add_op(ACT_APPEND, idx, pick_word(), n == 0 && $urandom_range(0, 2) == 0);
		end
		for (n = 0; n < pulls; n++) begin
			sel = $urandom_range(0, 49);
			if (sel == 0)
				add_op(ACT_CLEAR, 3'($urandom()), $urandom());
			else if (sel < 6)
				add_op(ACT_APPEND, 3'($urandom()), pick_word());
			else if (sel < 12)
				add_op(ACT_SPARE, 3'($urandom()), $urandom());
			else
				add_op(ACT_PULL, 3'($urandom()), $urandom());
		end
	endtask

	// push one queue past full, then drain everything or clear
	task automatic fill_phase(bit drain);
		logic [2:0] idx;
		int         n;
		idx = 3'($urandom_range(0, NQ - 1));
		for (n = 0; n < DEPTH + 3; n++)
			add_op(ACT_APPEND, idx, pick_word(), n == 0);
		if (drain) begin
			for (n = 0; n < DEPTH + 5; n++)
				add_op(ACT_PULL, 3'($urandom()), $urandom());
		end else begin
			add_op(ACT_CLEAR, 3'($urandom()), $urandom());
		end
	endtask

	// stimulus
	initial begin
		int ph;
		// directed: empty pulls, extremes, rotation, late load, clear
		add_op(ACT_PULL,   3'd5, 32'h1234_5678);
		add_op(ACT_SPARE,  3'd0, 32'h0000_0000);
		add_op(ACT_APPEND, 3'd0, 32'h7fff_ffff);
		add_op(ACT_APPEND, 3'd0, 32'h8000_0000);
		add_op(ACT_APPEND, 3'd7, 32'h0000_0000);
		add_op(ACT_APPEND, 3'd7, 32'hffff_ffff);
		add_op(ACT_APPEND, 3'd3, 32'h5555_5555);
		add_op(ACT_APPEND, 3'd3, 32'haaaa_aaaa);
		add_op(ACT_PULL,   3'd7, 32'hffff_ffff);
		add_op(ACT_SPARE,  3'd2, 32'h0000_0001);
		add_op(ACT_PULL,   3'd0, 32'h0000_0000);
		add_op(ACT_APPEND, 3'd1, 32'd42);
		add_op(ACT_PULL,   3'd4, 32'h0000_0000);
		add_op(ACT_PULL,   3'd4, 32'h0000_0000);
		add_op(ACT_PULL,   3'd4, 32'h0000_0000);
		add_op(ACT_PULL,   3'd4, 32'h0000_0000);
		add_op(ACT_PULL,   3'd4, 32'h0000_0000);
		add_op(ACT_APPEND, 3'd2, 32'h0000_1111);
		add_op(ACT_APPEND, 3'd5, 32'hffff_0000);
		add_op(ACT_CLEAR,  3'd6, 32'hffff_ffff);
		add_op(ACT_PULL,   3'd1, 32'h0000_0000);
		add_op(ACT_APPEND, 3'd4, -32'sd7, 1'b1);
		add_op(ACT_PULL,   3'd4, 32'h0000_0000);
		// random phases, two of them driving a queue to full
		ph = 0;
		while (op_backlog.size() < ITEMS || ph <= 13) begin
			if (ph == 5)
				fill_phase(1'b1);
			else if (ph == 13)
				fill_phase(1'b0);
			else
				mixed_phase();
			ph++;
		end
	end

	// driver
	always @(posedge clk) begin
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			next_start = start;
			// transaction taken at this edge
			if (start && !busy) begin
				due_results.insert(due_results.size(), interleave_step(item));
				accepted_count++;
				void'(op_backlog.pop_front());
				if ($urandom_range(0, 39) == 0)
					idle_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 8 : 30);
			end
			// pick what to present next
			if (!start || !busy) begin
				next_start = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (op_backlog.size() != 0 &&
						!(op_backlog[0].settle && accepted_count != results_seen)) begin
					if (op_backlog.size() > 120 && $urandom_range(0, 99) < idle_pct) begin
						gap_left = $urandom_range(0, 6);
					end else begin
						next_start = 1'b1;
						item <= op_backlog[0].op;
					end
				end
			end
			start <= next_start;
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: value_out %0d status %0d more_left %0d",
					result.value_out, result.status, result.more_left);
				fault_count++;
			end else begin
				want = due_results.pop_front();
				if (result.value_out !== want.value_out) begin
					$error("value_out: expected %0d, got %0d", want.value_out, result.value_out);
					fault_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fault_count++;
				end
				if (result.more_left !== want.more_left) begin
					$error("more_left: expected %0d, got %0d", want.more_left, result.more_left);
					fault_count++;
				end
				status_tally[want.status]++;
			end
			results_seen <= results_seen + 1;
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		do @(negedge clk); while (op_backlog.size() != 0 || start || accepted_count != results_seen);
		repeat (10) @(negedge clk);
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			fault_count++;
		end
		$display("%0d transactions over %0d queues of %0d words", results_seen, NQ, DEPTH);
		$display("delivered %0d, empty pulls %0d, appends %0d, refused %0d, clears %0d",
			status_tally[ST_DELIVERED], status_tally[ST_EMPTY], status_tally[ST_ACCEPTED],
			status_tally[ST_FULL], status_tally[ST_CLEARED]);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/rrqi_pkg.sv
hdl/round_robin_queue_interleaver.sv
sim/tb_top.sv
